FILE: rtl/core/spse_pkg.sv
// Shared types and constants for the sprite scanline evaluator.
// Used by spse_oam and sprite_scanline_evaluator_core; depends on nothing.
package spse_pkg;

    // Fixed geometry of the attribute store and its entries.
    localparam int STORE_BYTES   = 256;
    localparam int STORE_AW      = 8;
    localparam int ENTRY_IDX_W   = 6;
    localparam int SPRITE_HEIGHT = 8;
    localparam logic [7:0] EMPTY_BYTE = 8'hFF;

    // Stream widths; the data widths are padded to whole bytes.
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 48;

    // Operation codes carried in the input tuser.
    typedef enum logic [2:0] {
        FUNC_SET_ADDR  = 3'd0,
        FUNC_WRITE     = 3'd1,
        FUNC_READ      = 3'd2,
        FUNC_READ_ADDR = 3'd3,
        FUNC_EVAL      = 3'd4
    } func_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_COPY,
        ST_EMIT
    } state_t;

    // Write request into the attribute store.
    typedef struct packed {
        logic                en;
        logic [STORE_AW-1:0] addr;
        logic [7:0]          data;
    } oam_wr_t;

endpackage

FILE: rtl/core/sprite_scanline_evaluator_core.sv
// Top level of the sprite scanline evaluator: sequencer, secondary store, output register.
// Depends on spse_pkg and spse_oam.
//
// Channel  Dir  Handshake          Contents
// s_       in   s_tvalid/s_tready  tuser: func; tdata: data, scanline
// m_       out  m_tvalid/m_tready  tdata: read byte or one secondary slot; tlast
//
// Set address and write byte complete on acceptance. A read passes through ST_READ, which loads
// the registered store byte or the address into the output register; the input is ready again
// once that load is made. Evaluate scans the y byte of each entry, copies the remaining bytes of
// each chosen sprite, then emits one result per slot; the single read port of the attribute store
// sets the scan pace. Reset needs no clearing pass; valid bits cover the store.
// A stalled output holds the sequencer in place until the transaction completes.
module sprite_scanline_evaluator_core
    import spse_pkg::*;
#(
    parameter int SPRITE_COUNT  = 64,
    parameter int SLOT_COUNT    = 8,
    parameter int VISIBLE_LINES = 240
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // data[7:0], scanline[16:8], zero pad
    input  logic [S_TUSER_W-1:0] s_tuser,  // func[2:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // read_data[7:0], slot[10:8], sprite_y[18:11],
                                           // sprite_tile[26:19], sprite_attr[34:27],
                                           // sprite_x[42:35], zero_selected[43], zero pad
    output logic                 m_tlast
);

    localparam int ENT_W   = $clog2(SPRITE_COUNT + 1);
    localparam int CNT_W   = $clog2(SLOT_COUNT + 1);
    localparam int SLOT_IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    state_t                 state_reg, state_next;
    logic [STORE_AW-1:0]    addr_reg, addr_next;
    logic [8:0]             line_reg, line_next;
    logic [ENT_W-1:0]       ent_reg, ent_next;
    logic [ENTRY_IDX_W-1:0] chk_reg, chk_next;
    logic                   pend_reg, pend_next;
    logic [1:0]             cp_reg, cp_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   zero_reg, zero_next;
    logic [SLOT_IW-1:0]     k_reg, k_next;
    logic                   rdaddr_reg, rdaddr_next;
    logic [7:0]             ystage_reg, ystage_next;
    logic [7:0]             tile_reg, tile_next;
    logic [7:0]             attr_reg, attr_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic                   m_tlast_reg, m_tlast_next;
    logic [M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;

    logic [31:0]            sec_reg [SLOT_COUNT];
    logic                   sec_we;
    logic [31:0]            sec_rd;

    oam_wr_t                oam_wr;
    logic [STORE_AW-1:0]    oam_raddr;
    logic [7:0]             oam_rdata;

    logic                   in_hs;
    logic                   out_free;
    func_t                  func_in;
    logic [7:0]             data_in;
    logic [8:0]             line_in;
    logic                   y_match;
    logic [8:0]             y_ext;

    spse_oam u_oam (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (oam_wr),
        .raddr   (oam_raddr),
        .rdata   (oam_rdata)
    );

    assign func_in  = func_t'(s_tuser);
    assign data_in  = s_tdata[7:0];
    assign line_in  = s_tdata[16:8];
    assign s_tready = (state_reg == ST_IDLE);
    assign in_hs    = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // The single compare unit: y lies within the sprite height above the line.
    assign y_ext   = {1'b0, oam_rdata};
    assign y_match = (oam_rdata != EMPTY_BYTE) && (line_reg > y_ext) &&
                     (line_reg <= y_ext + 9'(SPRITE_HEIGHT));

    // Slots at or beyond the fill count read as empty.
    assign sec_rd = (CNT_W'(k_reg) < cnt_reg) ? sec_reg[k_reg] : {4{EMPTY_BYTE}};

    // Secondary store, written once per copied sprite.
    always_ff @(posedge aclk) begin
        if (sec_we) begin
            sec_reg[SLOT_IW'(cnt_reg)] <= {oam_rdata, attr_reg, tile_reg, ystage_reg};
        end
    end

    // Control and payload registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            addr_reg     <= '0;
            ent_reg      <= '0;
            pend_reg     <= 1'b0;
            cp_reg       <= '0;
            cnt_reg      <= '0;
            zero_reg     <= 1'b0;
            k_reg        <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            addr_reg     <= addr_next;
            ent_reg      <= ent_next;
            pend_reg     <= pend_next;
            cp_reg       <= cp_next;
            cnt_reg      <= cnt_next;
            zero_reg     <= zero_next;
            k_reg        <= k_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        line_reg    <= line_next;
        chk_reg     <= chk_next;
        rdaddr_reg  <= rdaddr_next;
        ystage_reg  <= ystage_next;
        tile_reg    <= tile_next;
        attr_reg    <= attr_next;
        m_tlast_reg <= m_tlast_next;
        m_tdata_reg <= m_tdata_next;
    end

    // Sequencer: next state, store accesses and output loading.
    always_comb begin
        state_next    = state_reg;
        addr_next     = addr_reg;
        line_next     = line_reg;
        ent_next      = ent_reg;
        chk_next      = chk_reg;
        pend_next     = pend_reg;
        cp_next       = cp_reg;
        cnt_next      = cnt_reg;
        zero_next     = zero_reg;
        k_next        = k_reg;
        rdaddr_next   = rdaddr_reg;
        ystage_next   = ystage_reg;
        tile_next     = tile_reg;
        attr_next     = attr_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tlast_next  = m_tlast_reg;
        m_tdata_next  = m_tdata_reg;
        oam_wr        = '0;
        oam_raddr     = addr_reg;
        sec_we        = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (in_hs) begin
                    case (func_in)
                        FUNC_SET_ADDR: begin
                            addr_next = data_in;
                        end
                        FUNC_WRITE: begin
                            oam_wr.en   = 1'b1;
                            oam_wr.addr = addr_reg;
                            oam_wr.data = data_in;
                            addr_next   = addr_reg + 1'b1;
                        end
                        FUNC_READ, FUNC_READ_ADDR: begin
                            rdaddr_next = (func_in == FUNC_READ_ADDR);
                            state_next  = ST_READ;
                        end
                        FUNC_EVAL: begin
                            k_next = '0;
                            if (line_in < 9'(VISIBLE_LINES)) begin
                                line_next  = line_in;
                                cnt_next   = '0;
                                zero_next  = 1'b0;
                                ent_next   = '0;
                                pend_next  = 1'b0;
                                state_next = ST_SCAN;
                            end else begin
                                state_next = ST_EMIT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_READ: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tlast_next  = 1'b1;
                    m_tdata_next  = '0;
                    m_tdata_next[7:0] = rdaddr_reg ? addr_reg : oam_rdata;
                    state_next    = ST_IDLE;
                end
            end

            ST_SCAN: begin
                oam_raddr = {6'(ent_reg), 2'b00};
                if (pend_reg && y_match) begin
                    // A match with no free slot ends the scan.
                    pend_next = 1'b0;
                    if (cnt_reg == CNT_W'(SLOT_COUNT)) begin
                        state_next = ST_EMIT;
                    end else begin
                        ystage_next = oam_rdata;
                        cp_next     = 2'd1;
                        state_next  = ST_COPY;
                    end
                end else if (ent_reg < ENT_W'(SPRITE_COUNT)) begin
                    chk_next  = 6'(ent_reg);
                    ent_next  = ent_reg + 1'b1;
                    pend_next = 1'b1;
                end else begin
                    pend_next  = 1'b0;
                    state_next = ST_EMIT;
                end
            end

            ST_COPY: begin
                // Bytes one to three are requested, each captured in the cycle after its request.
                oam_raddr = {chk_reg, cp_reg};
                cp_next   = cp_reg + 1'b1;
                case (cp_reg)
                    2'd2: tile_next = oam_rdata;
                    2'd3: attr_next = oam_rdata;
                    2'd0: begin
                        sec_we   = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                        if (chk_reg == '0) begin
                            zero_next = 1'b1;
                        end
                        state_next = ST_SCAN;
                    end
                    default: begin
                    end
                endcase
            end

            ST_EMIT: begin
                if (out_free) begin
                    m_tvalid_next       = 1'b1;
                    m_tlast_next        = (k_reg == SLOT_IW'(SLOT_COUNT - 1));
                    m_tdata_next        = '0;
                    m_tdata_next[10:8]  = 3'(k_reg);
                    m_tdata_next[42:11] = sec_rd;
                    m_tdata_next[43]    = zero_reg;
                    if (k_reg == SLOT_IW'(SLOT_COUNT - 1)) begin
                        k_next     = '0;
                        state_next = ST_IDLE;
                    end else begin
                        k_next = k_reg + 1'b1;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // The fill count never passes the number of slots.
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(SLOT_COUNT))
        else $error("secondary fill count exceeds slot count");

    // A copy only starts while a free slot remains.
    a_copy_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COPY) |-> (cnt_reg < CNT_W'(SLOT_COUNT)))
        else $error("copy started with no free slot");

    // Leaving the emit phase always leaves the final slot marked last in the output register.
    a_emit_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && state_next == ST_IDLE) |=> (m_tvalid_reg && m_tlast_reg))
        else $error("emit phase ended without a last result");

    // An evaluate transaction for a line outside the visible range goes straight to emitting.
    a_invisible: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_hs && func_in == FUNC_EVAL && line_in >= 9'(VISIBLE_LINES))
        |=> (state_reg == ST_EMIT))
        else $error("invisible line did not skip the scan");

endmodule

FILE: rtl/core/spse_oam.sv
// Sprite attribute store: 256 bytes, one write and one registered read a cycle.
// Per-byte valid bits make unwritten bytes read as 0xFF; depends on spse_pkg.
module spse_oam
    import spse_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  oam_wr_t             wr,
    input  logic [STORE_AW-1:0] raddr,
    output logic [7:0]          rdata
);

    logic [7:0]             mem [STORE_BYTES];
    logic [STORE_BYTES-1:0] valid_reg;
    logic [7:0]             rd_reg;
    logic                   rd_valid_reg;

    // Storage array and its registered read port.
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rd_reg <= mem[raddr];
    end

    // Valid bits stand in for the reset value of every byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr.en) begin
                valid_reg[wr.addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[raddr];
        end
    end

    assign rdata = rd_valid_reg ? rd_reg : EMPTY_BYTE;

endmodule
